>>> design/imh_pkg.sv
// Shared constants, codes and types for the indexed min-heap core.
`timescale 1ns / 1ps
package imh_pkg;

    localparam int HEAP_CAPACITY_DEF = 1024;
    localparam int HANDLE_SPACE_DEF  = 4096;
    localparam int VAL_W             = 32;
    localparam int CMD_W             = 3;
    localparam int STATUS_W          = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_PEEK   = 3'd1,
        CMD_DELMIN = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_CHANGE = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_BAD   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PEEK,
        S_FETCH0,
        S_LOOK,
        S_FETCHL,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_WB,
        S_DONE
    } state_t;

endpackage

>>> design/imh_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module imh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/indexed_min_heap_core.sv
// Top level of the indexed binary min-heap command engine.
//
// Input channel s_*: one transaction is one command. s_tuser carries the
// command code, s_tdata the value and the handle. Output channel m_*: one
// transaction per command with min_value, new_handle and entries in m_tdata
// and the status code in m_tuser.
// One command is worked at a time by a sequencer around two RAMs: the heap
// RAM (value and handle per slot) and the handle map RAM (live bit and slot
// per handle), each one read and one write per cycle. A sift-up level reads
// the parent, then compares; a sift-down level reads the left child, then the
// right child, then compares. A sift moves an entry at most 9 levels when the
// heap holds 1024 entries. s_tready is high only while the sequencer is idle;
// a new command may be taken while the previous result still waits in the
// output register. If the receiver stalls, the result holds and the next one
// waits in the sequencer until the output register frees.
// Reset (aresetn low, synchronous) empties the heap and the handle counter;
// the RAMs need no clearing pass.
`timescale 1ns / 1ps
module indexed_min_heap_core #(
    parameter int HEAP_CAPACITY = imh_pkg::HEAP_CAPACITY_DEF,
    parameter int HANDLE_SPACE  = imh_pkg::HANDLE_SPACE_DEF,
    localparam int SW   = $clog2(HEAP_CAPACITY),
    localparam int CW   = $clog2(HEAP_CAPACITY + 1),
    localparam int HIW  = $clog2(HANDLE_SPACE),
    localparam int HW   = $clog2(HANDLE_SPACE + 1),
    localparam int S_DW = ((imh_pkg::VAL_W + HW + 7) / 8) * 8,
    localparam int M_DW = ((imh_pkg::VAL_W + HW + CW + 7) / 8) * 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [S_DW-1:0]              s_tdata,  // value, handle, zero pad
    input  logic [imh_pkg::CMD_W-1:0]    s_tuser,  // command
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [M_DW-1:0]              m_tdata,  // min_value, new_handle, entries, pad
    output logic [imh_pkg::STATUS_W-1:0] m_tuser   // status
);

    import imh_pkg::*;

    localparam int HEAP_DW = VAL_W + HIW;
    localparam int MAP_DW  = SW + 1;

    state_t state_reg, state_next;

    logic [VAL_W-1:0] val_reg, val_next;
    logic [HW-1:0]    hdl_reg, hdl_next;
    cmd_t             cmd_reg, cmd_next;

    logic [CW-1:0]    count_reg, count_next;
    logic [HW-1:0]    issued_reg, issued_next;

    logic [VAL_W-1:0] cur_val_reg, cur_val_next;
    logic [HIW-1:0]   cur_hdl_reg, cur_hdl_next;
    logic [SW-1:0]    pos_reg, pos_next;
    logic             down_first_reg, down_first_next;
    logic             second_reg, second_next;

    logic [VAL_W-1:0] best_val_reg, best_val_next;
    logic [HIW-1:0]   best_hdl_reg, best_hdl_next;
    logic             best_child_reg, best_child_next;
    logic             have_r_reg, have_r_next;

    logic [VAL_W-1:0] res_min_reg, res_min_next;
    logic [HW-1:0]    res_newh_reg, res_newh_next;
    status_t          res_status_reg, res_status_next;

    logic             m_tvalid_reg, m_tvalid_next;
    logic [M_DW-1:0]  m_tdata_reg, m_tdata_next;
    status_t          m_tuser_reg, m_tuser_next;

    logic               heap_we;
    logic [SW-1:0]      heap_waddr, heap_raddr;
    logic [HEAP_DW-1:0] heap_wdata, heap_rdata;
    logic               map_we;
    logic [HIW-1:0]     map_waddr, map_raddr;
    logic [MAP_DW-1:0]  map_wdata, map_rdata;

    logic [VAL_W-1:0] in_val;
    logic [HW-1:0]    in_hdl;
    logic [HW-1:0]    in_hdl_m1, hdl_m1;
    logic             accept, is_full, is_empty, bad_hdl;
    logic [VAL_W-1:0] rd_val;
    logic [HIW-1:0]   rd_hdl;
    logic [SW-1:0]    parent_idx;
    logic [SW+1:0]    left_idx, right_idx, count_ext;
    logic [CW-1:0]    last_slot;
    logic             at_last, parent_gt, left_wins, right_wins, dn_move;
    logic             out_free;
    state_t           phase_end;

    imh_ram #(.WIDTH(HEAP_DW), .DEPTH(HEAP_CAPACITY)) u_heap_ram (
        .aclk  (aclk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .raddr (heap_raddr),
        .rdata (heap_rdata)
    );

    imh_ram #(.WIDTH(MAP_DW), .DEPTH(HANDLE_SPACE)) u_map_ram (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    assign in_val     = s_tdata[VAL_W-1:0];
    assign in_hdl     = s_tdata[VAL_W+HW-1:VAL_W];
    assign in_hdl_m1  = in_hdl - HW'(1);
    assign hdl_m1     = hdl_reg - HW'(1);
    assign accept     = s_tvalid && s_tready;
    assign is_full    = (count_reg >= CW'(HEAP_CAPACITY)) || (issued_reg >= HW'(HANDLE_SPACE));
    assign is_empty   = (count_reg == '0);
    assign bad_hdl    = (in_hdl == '0) || (in_hdl > issued_reg);
    assign rd_val     = heap_rdata[VAL_W-1:0];
    assign rd_hdl     = heap_rdata[HEAP_DW-1:VAL_W];
    assign parent_idx = (pos_reg - SW'(1)) >> 1;
    assign left_idx   = {1'b0, pos_reg, 1'b1};
    assign right_idx  = left_idx + (SW+2)'(1);
    assign count_ext  = (SW+2)'(count_reg);
    assign last_slot  = count_reg - CW'(1);
    assign at_last    = (CW'(pos_reg) == last_slot);
    assign parent_gt  = $signed(rd_val) > $signed(cur_val_reg);
    assign left_wins  = $signed(cur_val_reg) > $signed(rd_val);
    assign right_wins = have_r_reg && ($signed(best_val_reg) > $signed(rd_val));
    assign dn_move    = right_wins || best_child_reg;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign phase_end  = second_reg ? S_WB : (down_first_reg ? S_UP_RD : S_DN_RDL);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (cmd_t'(s_tuser))
                        CMD_INSERT: state_next = is_full ? S_DONE : S_UP_RD;
                        CMD_PEEK:   state_next = is_empty ? S_DONE : S_PEEK;
                        CMD_DELMIN: state_next = is_empty ? S_DONE : S_FETCH0;
                        CMD_DELETE,
                        CMD_CHANGE: state_next = bad_hdl ? S_DONE : S_LOOK;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_PEEK:   state_next = S_DONE;
            S_FETCH0: state_next = S_FETCHL;
            S_LOOK: begin
                if (!map_rdata[SW]) begin
                    state_next = S_DONE;
                end else if (cmd_reg == CMD_DELETE) begin
                    state_next = S_FETCHL;
                end else begin
                    state_next = S_DN_RDL;
                end
            end
            S_FETCHL: state_next = at_last ? S_DONE : S_UP_RD;
            S_UP_RD:  state_next = (pos_reg == '0) ? phase_end : S_UP_CMP;
            S_UP_CMP: state_next = parent_gt ? S_UP_RD : phase_end;
            S_DN_RDL: state_next = (left_idx < count_ext) ? S_DN_RDR : phase_end;
            S_DN_RDR: state_next = S_DN_CMP;
            S_DN_CMP: state_next = dn_move ? S_DN_RDL : phase_end;
            S_WB:     state_next = S_DONE;
            S_DONE:   state_next = out_free ? S_IDLE : S_DONE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        val_next        = val_reg;
        hdl_next        = hdl_reg;
        cmd_next        = cmd_reg;
        count_next      = count_reg;
        issued_next     = issued_reg;
        cur_val_next    = cur_val_reg;
        cur_hdl_next    = cur_hdl_reg;
        pos_next        = pos_reg;
        down_first_next = down_first_reg;
        second_next     = second_reg;
        best_val_next   = best_val_reg;
        best_hdl_next   = best_hdl_reg;
        best_child_next = best_child_reg;
        have_r_next     = have_r_reg;
        res_min_next    = res_min_reg;
        res_newh_next   = res_newh_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        heap_we         = 1'b0;
        heap_waddr      = pos_reg;
        heap_wdata      = {cur_hdl_reg, cur_val_reg};
        heap_raddr      = '0;
        map_we          = 1'b0;
        map_waddr       = cur_hdl_reg;
        map_wdata       = {1'b1, pos_reg};
        map_raddr       = in_hdl_m1[HIW-1:0];

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if ((state_reg == S_UP_RD && pos_reg == '0)
            || (state_reg == S_UP_CMP && !parent_gt)
            || (state_reg == S_DN_RDL && !(left_idx < count_ext))
            || (state_reg == S_DN_CMP && !dn_move)) begin
            second_next = 1'b1;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    val_next        = in_val;
                    hdl_next        = in_hdl;
                    cmd_next        = cmd_t'(s_tuser);
                    res_min_next    = '0;
                    res_newh_next   = '0;
                    res_status_next = STAT_OK;
                    down_first_next = 1'b0;
                    second_next     = 1'b0;
                    case (cmd_t'(s_tuser))
                        CMD_INSERT: begin
                            if (is_full) begin
                                res_status_next = STAT_FULL;
                            end else begin
                                cur_val_next  = in_val;
                                cur_hdl_next  = issued_reg[HIW-1:0];
                                pos_next      = count_reg[SW-1:0];
                                issued_next   = issued_reg + HW'(1);
                                count_next    = count_reg + CW'(1);
                                res_newh_next = issued_reg + HW'(1);
                            end
                        end
                        CMD_PEEK, CMD_DELMIN: begin
                            if (is_empty) begin
                                res_status_next = STAT_EMPTY;
                            end
                        end
                        CMD_DELETE, CMD_CHANGE: begin
                            if (bad_hdl) begin
                                res_status_next = STAT_BAD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_PEEK: begin
                res_min_next = rd_val;
            end
            S_FETCH0: begin
                map_we     = 1'b1;
                map_waddr  = rd_hdl;
                map_wdata  = {1'b0, SW'(0)};
                pos_next   = '0;
                heap_raddr = last_slot[SW-1:0];
            end
            S_LOOK: begin
                if (!map_rdata[SW]) begin
                    res_status_next = STAT_BAD;
                end else if (cmd_reg == CMD_DELETE) begin
                    map_we     = 1'b1;
                    map_waddr  = hdl_m1[HIW-1:0];
                    map_wdata  = {1'b0, SW'(0)};
                    pos_next   = map_rdata[SW-1:0];
                    heap_raddr = last_slot[SW-1:0];
                end else begin
                    cur_val_next    = val_reg;
                    cur_hdl_next    = hdl_m1[HIW-1:0];
                    pos_next        = map_rdata[SW-1:0];
                    down_first_next = 1'b1;
                end
            end
            S_FETCHL: begin
                cur_val_next    = rd_val;
                cur_hdl_next    = rd_hdl;
                count_next      = last_slot;
                down_first_next = 1'b0;
                second_next     = 1'b0;
            end
            S_UP_RD: begin
                heap_raddr = parent_idx;
            end
            S_UP_CMP: begin
                if (parent_gt) begin
                    heap_we    = 1'b1;
                    heap_wdata = heap_rdata;
                    map_we     = 1'b1;
                    map_waddr  = rd_hdl;
                    pos_next   = parent_idx;
                end
            end
            S_DN_RDL: begin
                heap_raddr = left_idx[SW-1:0];
            end
            S_DN_RDR: begin
                heap_raddr  = right_idx[SW-1:0];
                have_r_next = right_idx < count_ext;
                if (left_wins) begin
                    best_val_next   = rd_val;
                    best_hdl_next   = rd_hdl;
                    best_child_next = 1'b1;
                end else begin
                    best_val_next   = cur_val_reg;
                    best_hdl_next   = cur_hdl_reg;
                    best_child_next = 1'b0;
                end
            end
            S_DN_CMP: begin
                if (dn_move) begin
                    heap_we = 1'b1;
                    map_we  = 1'b1;
                    if (right_wins) begin
                        heap_wdata = heap_rdata;
                        map_waddr  = rd_hdl;
                        pos_next   = right_idx[SW-1:0];
                    end else begin
                        heap_wdata = {best_hdl_reg, best_val_reg};
                        map_waddr  = best_hdl_reg;
                        pos_next   = left_idx[SW-1:0];
                    end
                end
            end
            S_WB: begin
                heap_we = 1'b1;
                map_we  = 1'b1;
            end
            S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_DW'({count_reg, res_newh_reg, res_min_reg});
                    m_tuser_next  = res_status_reg;
                end
            end
            default: ;
        endcase

        // peek reads slot 0 while still idle
        if (state_reg == S_IDLE) begin
            heap_raddr = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            issued_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            issued_reg   <= issued_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg        <= val_next;
        hdl_reg        <= hdl_next;
        cmd_reg        <= cmd_next;
        cur_val_reg    <= cur_val_next;
        cur_hdl_reg    <= cur_hdl_next;
        pos_reg        <= pos_next;
        down_first_reg <= down_first_next;
        second_reg     <= second_next;
        best_val_reg   <= best_val_next;
        best_hdl_reg   <= best_hdl_next;
        best_child_reg <= best_child_next;
        have_r_reg     <= have_r_next;
        res_min_reg    <= res_min_next;
        res_newh_reg   <= res_newh_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> design/imh_checker.sv
// Port-level assertions for the indexed min-heap core, bound to the top level.
`timescale 1ns / 1ps
module imh_checker #(
    parameter int HEAP_CAPACITY = imh_pkg::HEAP_CAPACITY_DEF,
    parameter int HANDLE_SPACE  = imh_pkg::HANDLE_SPACE_DEF,
    localparam int CW   = $clog2(HEAP_CAPACITY + 1),
    localparam int HW   = $clog2(HANDLE_SPACE + 1),
    localparam int S_DW = ((imh_pkg::VAL_W + HW + 7) / 8) * 8,
    localparam int M_DW = ((imh_pkg::VAL_W + HW + CW + 7) / 8) * 8
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [S_DW-1:0]              s_tdata,
    input logic [imh_pkg::CMD_W-1:0]    s_tuser,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [M_DW-1:0]              m_tdata,
    input logic [imh_pkg::STATUS_W-1:0] m_tuser
);

    import imh_pkg::*;

    logic [HW-1:0] out_newh;
    logic [CW-1:0] out_entries;

    assign out_newh    = m_tdata[VAL_W+HW-1:VAL_W];
    assign out_entries = m_tdata[VAL_W+HW+CW-1:VAL_W+HW];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command taken while busy");

    a_newh: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STAT_OK |-> out_newh == '0)
        else $error("handle given on failed command");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STAT_EMPTY |-> out_entries == '0)
        else $error("empty status with entries");

    a_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_entries <= CW'(HEAP_CAPACITY))
        else $error("entry count above capacity");

endmodule

bind indexed_min_heap_core imh_checker #(
    .HEAP_CAPACITY (HEAP_CAPACITY),
    .HANDLE_SPACE  (HANDLE_SPACE)
) u_imh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> tb/tb_top.sv
// Self-checking testbench for the indexed min-heap core.
`timescale 1ns / 1ps
module tb_top;
    import imh_pkg::*;

    localparam int CAP   = 1024;
    localparam int HSP   = 4096;
    localparam int S_DW  = 48;
    localparam int M_DW  = 56;
    localparam int NRAND = 675;

    typedef struct packed {
        logic [31:0] min_value;
        logic [12:0] new_handle;
        logic [1:0]  status;
        logic [10:0] entries;
    } heap_rsp_t;

    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] value;
        logic [12:0] handle;
        bit          typed;
        heap_rsp_t   rsp;
    } dir_row_t;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [S_DW-1:0] s_tdata = '0;
    logic [2:0]      s_tuser = '0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [M_DW-1:0] m_tdata;
    logic [1:0]      m_tuser;

    indexed_min_heap_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow heap state
    logic signed [31:0] hv[CAP];
    int                 s2h[CAP];
    int                 h2s[HSP];
    bit                 hlive[HSP];
    int                 cnt, issued;

    heap_rsp_t pending_rsp[$];
    int        errors, rsp_seen, tx_sent;
    int        send_idle, recv_idle;
    int        n_ok, n_empty, n_full, n_bad;

    function automatic void swap_slots(int a, int b);
        logic signed [31:0] tv;
        int                 th;
        tv = hv[a]; hv[a] = hv[b]; hv[b] = tv;
        th = s2h[a]; s2h[a] = s2h[b]; s2h[b] = th;
        h2s[s2h[a]] = a;
        h2s[s2h[b]] = b;
    endfunction

    function automatic void sift_up(int u);
        int p;
        while (u > 0) begin
            p = (u - 1) / 2;
            if (!(hv[p] > hv[u])) break;
            swap_slots(u, p);
            u = p;
        end
    endfunction

    function automatic void sift_down(int u);
        int t, l, r;
        forever begin
            t = u; l = 2 * u + 1; r = l + 1;
            if (l < cnt && hv[t] > hv[l]) t = l;
            if (r < cnt && hv[t] > hv[r]) t = r;
            if (t == u) break;
            swap_slots(u, t);
            u = t;
        end
    endfunction

    function automatic void remove_slot(int k);
        int last;
        last = cnt - 1;
        hlive[s2h[k]] = 1'b0;
        if (k != last) begin
            swap_slots(k, last);
            cnt--;
            sift_up(k);
            sift_down(k);
        end else begin
            cnt--;
        end
    endfunction

    function automatic heap_rsp_t heap_apply(logic [2:0] cmd, logic [31:0] val,
                                             logic [12:0] hdl);
        heap_rsp_t r;
        int        k;
        r = '0;
        case (cmd)
            CMD_INSERT: begin
                if (cnt >= CAP || issued >= HSP) begin
                    r.status = STAT_FULL;
                end else begin
                    hv[cnt] = val; s2h[cnt] = issued; h2s[issued] = cnt;
                    hlive[issued] = 1'b1;
                    issued++; cnt++;
                    sift_up(cnt - 1);
                    r.new_handle = 13'(issued);
                end
            end
            CMD_PEEK, CMD_DELMIN: begin
                if (cnt == 0) r.status = STAT_EMPTY;
                else if (cmd == CMD_PEEK) r.min_value = hv[0];
                else remove_slot(0);
            end
            CMD_DELETE, CMD_CHANGE: begin
                if (hdl == 0 || hdl > issued || !hlive[hdl - 1]) begin
                    r.status = STAT_BAD;
                end else begin
                    k = h2s[hdl - 1];
                    if (cmd == CMD_DELETE) begin
                        remove_slot(k);
                    end else begin
                        hv[k] = val;
                        sift_down(k);
                        sift_up(h2s[hdl - 1]);
                    end
                end
            end
            default: ;
        endcase
        r.entries = 11'(cnt);
        return r;
    endfunction

    task automatic send_cmd(logic [2:0] cmd, logic [31:0] val, logic [12:0] hdl);
        if ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b0, hdl, val};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_rsp.push_back(heap_apply(cmd, val, hdl));
        tx_sent++;
    endtask

    // receiver: random stall, compare each transaction
    always @(posedge aclk) begin
        heap_rsp_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.min_value  = m_tdata[31:0];
            got.new_handle = m_tdata[44:32];
            got.entries    = m_tdata[55:45];
            got.status     = m_tuser;
            rsp_seen++;
            case (got.status)
                STAT_OK: n_ok++;
                STAT_EMPTY: n_empty++;
                STAT_FULL: n_full++;
                default: n_bad++;
            endcase
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected transaction, actual %h", $time, got);
                errors++;
            end else begin
                want = pending_rsp.pop_front();
                if (got.min_value !== want.min_value)
                    $display("%0t: min_value expected %h actual %h", $time,
                             want.min_value, got.min_value);
                if (got.new_handle !== want.new_handle)
                    $display("%0t: new_handle expected %0d actual %0d", $time,
                             want.new_handle, got.new_handle);
                if (got.status !== want.status)
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, got.status);
                if (got.entries !== want.entries)
                    $display("%0t: entries expected %0d actual %0d", $time,
                             want.entries, got.entries);
                if (got !== want) errors++;
            end
        end
        m_tready <= aresetn && ($urandom_range(99) >= recv_idle);
    end

    function automatic logic [12:0] pick_handle();
        int i;
        if (cnt > 0 && $urandom_range(9) < 8) begin
            i = $urandom_range(cnt - 1);
            return 13'(s2h[i] + 1);
        end
        case ($urandom_range(2))
            0: return 13'd0;
            1: return 13'(issued + 1 + $urandom_range(20));
            default: return 13'($urandom_range(issued));
        endcase
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(15) - 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic rand_cmd();
        int          p;
        logic [2:0]  cmd;
        p = $urandom_range(99);
        if (p < 40 || cnt < 3) cmd = CMD_INSERT;
        else if (p < 55) cmd = CMD_PEEK;
        else if (p < 70) cmd = CMD_DELMIN;
        else if (p < 82) cmd = CMD_DELETE;
        else if (p < 97) cmd = CMD_CHANGE;
        else cmd = 3'($urandom_range(5, 7));
        if (p >= 40 && cnt < 3 && $urandom_range(3) == 0) cmd = CMD_DELMIN;
        send_cmd(cmd, pick_value(), pick_handle());
    endtask

    dir_row_t dir_rows[$];

    function automatic void row(logic [2:0] c, logic [31:0] v, logic [12:0] h, bit t,
                                logic [31:0] mv, logic [12:0] nh, logic [1:0] st,
                                logic [10:0] en);
        dir_row_t d;
        d.cmd = c; d.value = v; d.handle = h; d.typed = t;
        d.rsp = '{mv, nh, st, en};
        dir_rows.push_back(d);
    endfunction

    initial begin
        #20_000_000;
        $display("[indexed_min_heap_core] ERROR");
        $finish;
    end

    initial begin
        heap_rsp_t want;
        int        pass;
        errors = 0; rsp_seen = 0; tx_sent = 0;
        n_ok = 0; n_empty = 0; n_full = 0; n_bad = 0;
        cnt = 0; issued = 0;
        foreach (hlive[i]) hlive[i] = 1'b0;
        send_idle = 33; recv_idle = 62;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        row(CMD_PEEK,   0, 0, 1, 0, 0, STAT_EMPTY, 0);
        row(CMD_DELMIN, 0, 0, 1, 0, 0, STAT_EMPTY, 0);
        row(CMD_DELETE, 0, 1, 1, 0, 0, STAT_BAD, 0);
        row(CMD_CHANGE, 5, 0, 1, 0, 0, STAT_BAD, 0);
        row(CMD_INSERT, 32'h7fff_ffff, 0, 1, 0, 1, STAT_OK, 1);
        row(CMD_INSERT, 32'h8000_0000, 0, 1, 0, 2, STAT_OK, 2);
        row(CMD_PEEK,   0, 0, 1, 32'h8000_0000, 0, STAT_OK, 2);
        row(CMD_INSERT, 0, 0, 0, 0, 0, 0, 0);
        row(CMD_INSERT, 32'hffff_ffff, 0, 0, 0, 0, 0, 0);
        row(CMD_INSERT, 32'hffff_ffff, 0, 0, 0, 0, 0, 0);
        row(CMD_DELETE, 0, 13'h1fff, 1, 0, 0, STAT_BAD, 5);
        row(CMD_DELETE, 0, 6, 1, 0, 0, STAT_BAD, 5);
        row(5, 32'hffff_ffff, 13'h1fff, 1, 0, 0, STAT_OK, 5);
        row(7, 0, 0, 1, 0, 0, STAT_OK, 5);
        row(CMD_CHANGE, 32'h8000_0000, 1, 0, 0, 0, 0, 0);
        row(CMD_PEEK,   0, 0, 0, 0, 0, 0, 0);
        row(CMD_CHANGE, 32'h7fff_ffff, 2, 0, 0, 0, 0, 0);
        row(CMD_DELETE, 0, 5, 0, 0, 0, 0, 0);
        row(CMD_DELETE, 0, 5, 1, 0, 0, STAT_BAD, 4);
        row(CMD_DELMIN, 0, 0, 0, 0, 0, 0, 0);
        row(CMD_PEEK,   0, 0, 0, 0, 0, 0, 0);
        row(CMD_DELMIN, 0, 0, 0, 0, 0, 0, 0);
        row(CMD_DELMIN, 0, 0, 0, 0, 0, 0, 0);
        row(CMD_DELMIN, 0, 0, 0, 0, 0, 0, 0);
        row(CMD_DELMIN, 0, 0, 1, 0, 0, STAT_EMPTY, 0);

        foreach (dir_rows[i]) begin
            want = heap_apply(dir_rows[i].cmd, dir_rows[i].value, dir_rows[i].handle);
            if (dir_rows[i].typed && want !== dir_rows[i].rsp) begin
                $display("%0t: row %0d table expected %h model %h", $time, i,
                         dir_rows[i].rsp, want);
                errors++;
            end
        end
        // restore shadow to reset and replay through the block
        cnt = 0; issued = 0;
        foreach (hlive[i]) hlive[i] = 1'b0;
        foreach (dir_rows[i]) send_cmd(dir_rows[i].cmd, dir_rows[i].value,
                                       dir_rows[i].handle);

        for (pass = 0; pass < 3; pass++) begin
            if (pass == 1) begin send_idle = 62; recv_idle = 33; end
            if (pass == 2) begin send_idle = 0;  recv_idle = 0;  end
            repeat (NRAND / 3) rand_cmd();
        end
        s_tvalid <= 1'b0;

        while (pending_rsp.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        $display("%0d commands sent, %0d results: ok %0d, empty %0d, full %0d, bad %0d",
                 tx_sent, rsp_seen, n_ok, n_empty, n_full, n_bad);
        $display("handles issued %0d, entries at end %0d", issued, cnt);
        if (errors == 0 && pending_rsp.size() == 0)
            $display("[indexed_min_heap_core] OK");
        else
            $display("[indexed_min_heap_core] ERROR");
        $finish;
    end
endmodule
